FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the DHCP reply parser.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/drp_pkg.sv
// Shared types and constants for the DHCP reply parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package drp_pkg;

  localparam int POS_W = 12;
  typedef logic [POS_W-1:0] pos_t;

  // Frame geometry
  localparam pos_t MAX_FRAME_BYTES = 12'd2048;
  localparam pos_t POS_LIMIT       = 12'd4095;
  localparam pos_t OPTIONS_START   = 12'd282;
  localparam pos_t MIN_LAST_POS    = 12'd281;  // last byte here gives length 282

  // Header byte positions
  localparam pos_t POS_DPORT_HI = 12'd36;
  localparam pos_t POS_DPORT_LO = 12'd37;
  localparam pos_t POS_OP       = 12'd42;
  localparam pos_t POS_XID0     = 12'd46;
  localparam pos_t POS_XID1     = 12'd47;
  localparam pos_t POS_XID2     = 12'd48;
  localparam pos_t POS_XID3     = 12'd49;
  localparam pos_t POS_YIADDR0  = 12'd58;
  localparam pos_t POS_YIADDR1  = 12'd59;
  localparam pos_t POS_YIADDR2  = 12'd60;
  localparam pos_t POS_YIADDR3  = 12'd61;

  // Expected header values
  localparam logic [7:0] DPORT_HI_VAL = 8'd0;
  localparam logic [7:0] DPORT_LO_VAL = 8'd68;
  localparam logic [7:0] OP_REPLY     = 8'd2;

  // Option codes
  localparam logic [7:0] OPT_PAD    = 8'd0;
  localparam logic [7:0] OPT_ROUTER = 8'd3;
  localparam logic [7:0] OPT_DNS    = 8'd6;
  localparam logic [7:0] OPT_END    = 8'd255;

  localparam logic [2:0] CAPTURE_BYTES = 3'd4;

  // Option walker phase
  typedef enum logic [3:0] {
    PH_CODE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // Per-byte control from the top level to the parsing units
  typedef struct packed {
    logic step;        // the byte in the input register is consumed
    logic clear;       // it is the last byte: return frame state to reset
    logic active;      // position below the maximum frame size
    logic opt_active;  // position inside the options area
  } byte_ctl_t;

  // Pending router and DNS values, including the current byte
  typedef struct packed {
    logic        gw_vld;
    logic [31:0] gw;
    logic        dns_vld;
    logic [31:0] dns;
  } opt_res_t;

endpackage

FILE: rtl/dhcp_reply_parser.sv
// DHCP reply parser top level: input register, byte position, commit and
// result register. Depends on drp_pkg, drp_hdr_check, drp_opt_walk and
// assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready): one frame byte per item, with
//   in_last_byte set on the final byte. Result channel (out_valid/out_ready):
//   one item per frame, produced by its last byte, carrying the accept flag
//   and the stored own, gateway and DNS addresses. cfg_we/cfg_wdata write the
//   expected transaction id; write it between frames.
//   Throughput: one byte per cycle unless a last byte waits for the result
//   register. Each byte passes the input register and compare/update logic
//   into the result register, which is loaded as the last byte leaves.
//   Reset (rst_n low, synchronous) clears the frame state, the stored
//   addresses and the transaction id.
//   When the receiver stalls, bytes keep streaming until a last byte reaches
//   the input register; that byte waits there until the result register
//   frees, and in_ready drops behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dhcp_reply_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [31:0] out_own_address,
  output logic [31:0] out_gateway_address,
  output logic [31:0] out_dns_address
);

  logic [31:0]        xid_r;
  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_last_r;
  logic               s1_go;
  drp_pkg::pos_t      pos_r;
  drp_pkg::byte_ctl_t ctl;
  logic               hdr_ok;
  logic [31:0]        yiaddr;
  drp_pkg::opt_res_t  opt_res;
  logic [31:0]        st_addr_r, st_addr_nxt;
  logic [31:0]        st_gw_r, st_gw_nxt;
  logic [31:0]        st_dns_r, st_dns_nxt;
  logic               bound;
  logic               take;
  logic               acc_nxt;
  logic               out_valid_r;
  logic               out_acc_r;
  logic [31:0]        out_addr_r;
  logic [31:0]        out_gw_r;
  logic [31:0]        out_dns_r;

  // Transaction id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xid_r <= '0;
    end else if (cfg_we) begin
      xid_r <= cfg_wdata;
    end
  end

  // Input register; a last byte waits here for the result register
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_frame_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Byte control for the parsing units
  always_comb begin
    ctl.step       = s1_go;
    ctl.clear      = s1_go && s1_last_r;
    ctl.active     = pos_r < drp_pkg::MAX_FRAME_BYTES;
    ctl.opt_active = ctl.active && (pos_r >= drp_pkg::OPTIONS_START);
  end

  // Byte position, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (ctl.step) begin
      if (ctl.clear) begin
        pos_r <= '0;
      end else if (pos_r != drp_pkg::POS_LIMIT) begin
        pos_r <= pos_r + 12'd1;
      end
    end
  end

  drp_hdr_check u_hdr (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .pos    (pos_r),
    .data   (s1_byte_r),
    .xid    (xid_r),
    .hdr_ok (hdr_ok),
    .yiaddr (yiaddr)
  );

  drp_opt_walk u_opt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .data  (s1_byte_r),
    .res   (opt_res)
  );

  // Commit decision at the last byte; length >= 282 means pos >= 281
  always_comb begin
    bound       = |st_addr_r[31:24];
    take        = !bound && hdr_ok && (pos_r >= drp_pkg::MIN_LAST_POS);
    acc_nxt     = bound || take;
    st_addr_nxt = take ? yiaddr : st_addr_r;
    st_gw_nxt   = (take && opt_res.gw_vld) ? opt_res.gw : st_gw_r;
    st_dns_nxt  = (take && opt_res.dns_vld) ? opt_res.dns : st_dns_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_addr_r <= '0;
      st_gw_r   <= '0;
      st_dns_r  <= '0;
    end else if (ctl.clear) begin
      st_addr_r <= st_addr_nxt;
      st_gw_r   <= st_gw_nxt;
      st_dns_r  <= st_dns_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.clear) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      out_acc_r  <= acc_nxt;
      out_addr_r <= st_addr_nxt;
      out_gw_r   <= st_gw_nxt;
      out_dns_r  <= st_dns_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_own_address     = out_addr_r;
  assign out_gateway_address = out_gw_r;
  assign out_dns_address     = out_dns_r;

  // Checks
  `DRP_ASSERT_IMP(a_no_overwrite, ctl.clear, !out_valid_r || out_ready, "result overwritten while stalled")
  `DRP_ASSERT_IMP(a_bound_accepts, out_valid_r && (|out_addr_r[31:24]), out_acc_r, "bound address not accepted")
  `DRP_ASSERT_NXT(a_pos_cleared, ctl.clear, pos_r == '0, "position not cleared after last byte")

endmodule

FILE: rtl/drp_hdr_check.sv
// Header checks (UDP port, op, transaction id) and offered address capture.
// Depends on drp_pkg.
`timescale 1ns / 1ps

module drp_hdr_check (
  input  logic                clk,
  input  logic                rst_n,
  input  drp_pkg::byte_ctl_t  ctl,
  input  drp_pkg::pos_t       pos,
  input  logic [7:0]          data,
  input  logic [31:0]         xid,
  output logic                hdr_ok,
  output logic [31:0]         yiaddr
);

  logic        ok_r;
  logic        ok_nxt;
  logic [31:0] addr_r;
  logic [31:0] addr_nxt;

  // Compare the header byte at its position, or shift in an offered address byte
  always_comb begin
    ok_nxt   = ok_r;
    addr_nxt = addr_r;
    if (ctl.active) begin
      case (pos)
        drp_pkg::POS_DPORT_HI: if (data != drp_pkg::DPORT_HI_VAL) ok_nxt = 1'b0;
        drp_pkg::POS_DPORT_LO: if (data != drp_pkg::DPORT_LO_VAL) ok_nxt = 1'b0;
        drp_pkg::POS_OP:       if (data != drp_pkg::OP_REPLY) ok_nxt = 1'b0;
        drp_pkg::POS_XID0:     if (data != xid[31:24]) ok_nxt = 1'b0;
        drp_pkg::POS_XID1:     if (data != xid[23:16]) ok_nxt = 1'b0;
        drp_pkg::POS_XID2:     if (data != xid[15:8]) ok_nxt = 1'b0;
        drp_pkg::POS_XID3:     if (data != xid[7:0]) ok_nxt = 1'b0;
        drp_pkg::POS_YIADDR0,
        drp_pkg::POS_YIADDR1,
        drp_pkg::POS_YIADDR2,
        drp_pkg::POS_YIADDR3:  addr_nxt = {addr_r[23:0], data};
        default: begin
        end
      endcase
    end
  end

  // Frame state, back to reset after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r   <= 1'b1;
      addr_r <= '0;
    end else if (ctl.step) begin
      if (ctl.clear) begin
        ok_r   <= 1'b1;
        addr_r <= '0;
      end else begin
        ok_r   <= ok_nxt;
        addr_r <= addr_nxt;
      end
    end
  end

  // View including the current byte, used at commit
  assign hdr_ok = ok_nxt;
  assign yiaddr = addr_nxt;

endmodule

FILE: rtl/drp_opt_walk.sv
// DHCP option walker: pad/end/TLV parsing, router and DNS capture.
// Depends on drp_pkg.
`timescale 1ns / 1ps

module drp_opt_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  drp_pkg::byte_ctl_t  ctl,
  input  logic [7:0]          data,
  output drp_pkg::opt_res_t   res
);

  drp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      code_r, code_nxt;
  logic [7:0]      remain_r, remain_nxt;
  logic [31:0]     cap_r, cap_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  drp_pkg::opt_res_t pend_r, pend_nxt;

  // One option byte per step
  always_comb begin
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    remain_nxt = remain_r;
    cap_nxt    = cap_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    if (ctl.opt_active) begin
      case (phase_r)
        drp_pkg::PH_CODE: begin
          if (data == drp_pkg::OPT_END) begin
            phase_nxt = drp_pkg::PH_DONE;
          end else if (data != drp_pkg::OPT_PAD) begin
            code_nxt  = data;
            phase_nxt = drp_pkg::PH_LEN;
          end
        end
        drp_pkg::PH_LEN: begin
          remain_nxt = data;
          cap_nxt    = '0;
          cnt_nxt    = '0;
          phase_nxt  = (data == 8'd0) ? drp_pkg::PH_CODE : drp_pkg::PH_DATA;
        end
        drp_pkg::PH_DATA: begin
          if (cnt_r < drp_pkg::CAPTURE_BYTES) begin
            cap_nxt = {cap_r[23:0], data};
            cnt_nxt = cnt_r + 3'd1;
          end
          remain_nxt = remain_r - 8'd1;
          // option complete: apply a full four-byte capture
          if (remain_nxt == 8'd0) begin
            if (cnt_nxt == drp_pkg::CAPTURE_BYTES) begin
              if (code_r == drp_pkg::OPT_ROUTER) begin
                pend_nxt.gw_vld = 1'b1;
                pend_nxt.gw     = cap_nxt;
              end
              if (code_r == drp_pkg::OPT_DNS) begin
                pend_nxt.dns_vld = 1'b1;
                pend_nxt.dns     = cap_nxt;
              end
            end
            phase_nxt = drp_pkg::PH_CODE;
          end
        end
        drp_pkg::PH_DONE: begin
        end
        default: phase_nxt = drp_pkg::PH_CODE;
      endcase
    end
  end

  // Walker state, back to reset after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= drp_pkg::PH_CODE;
      code_r   <= '0;
      remain_r <= '0;
      cap_r    <= '0;
      cnt_r    <= '0;
      pend_r   <= '0;
    end else if (ctl.step) begin
      if (ctl.clear) begin
        phase_r  <= drp_pkg::PH_CODE;
        code_r   <= '0;
        remain_r <= '0;
        cap_r    <= '0;
        cnt_r    <= '0;
        pend_r   <= '0;
      end else begin
        phase_r  <= phase_nxt;
        code_r   <= code_nxt;
        remain_r <= remain_nxt;
        cap_r    <= cap_nxt;
        cnt_r    <= cnt_nxt;
        pend_r   <= pend_nxt;
      end
    end
  end

  assign res = pend_nxt;

endmodule
